FILE: hw/rtl/spq_pkg.sv
// Shared types, constants and address helpers for the sorted priority queue.
// No dependencies; the queue module and the testbench refer to this package.
package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 64;
  localparam int PRIO_W   = 32;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ENTRY_W  = KEY_BITS + PRIO_W;

  localparam logic [PTR_W:0]   DEPTH_WRAP = (PTR_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_POP,
    S_SRCH,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e                    status;
    logic [KEY_BITS-1:0]        key;
    logic signed [PRIO_W-1:0]   prio;
    logic [PTR_W-1:0]           pos;
    logic [CNT_W-1:0]           occ;
  } res_t;

  // Map a place counted from the head onto a physical slot of the ring.
  function automatic logic [PTR_W-1:0] phys_addr(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_WRAP) begin
      sum = sum - DEPTH_WRAP;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/spq_if.sv
// Valid/ready channel interfaces for the sorted priority queue.
// Command items in, result items out; payload widths are fixed.
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [63:0]        item_key;
  logic signed [31:0] item_priority;

  modport source (output valid, command, item_key, item_priority, input ready);
  modport sink   (input valid, command, item_key, item_priority, output ready);
endinterface

interface spq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [63:0]        result_key;
  logic signed [31:0] result_priority;
  logic [3:0]         position;
  logic [4:0]         occupancy;

  modport source (output valid, status, result_key, result_priority, position, occupancy,
                  input ready);
  modport sink   (input valid, status, result_key, result_priority, position, occupancy,
                  output ready);
endinterface

FILE: hw/rtl/sorted_priority_queue.sv
// Sorted priority queue: up to DEPTH entries held in one RAM used as a ring from a head pointer.
// Pop takes the head entry; search and insert walk the RAM one entry per cycle, while a full
// insert, an empty pop or search and an unused command go straight to the result stage.
// One item at a time: the next is taken the cycle after the result loads; a waiting result
// holds off the following item only once that item reaches RESP.
// Reset (rst_ni low, async) empties the queue; RAM left as is. Needs spq_pkg, spq_if, spq_ram.
module sorted_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  spq_in_if.sink        in_i,
  spq_out_if.source     out_o
);

  localparam int PTR_W    = spq_pkg::PTR_W;
  localparam int CNT_W    = spq_pkg::CNT_W;
  localparam int KEY_BITS = spq_pkg::KEY_BITS;
  localparam int PRIO_W   = spq_pkg::PRIO_W;

  spq_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]         cnt_q, cnt_d;     // entries held
  logic [PTR_W-1:0]         head_q, head_d;   // physical slot of the head
  logic [PTR_W-1:0]         idx_q, idx_d;     // walk position, counted from the head
  logic [KEY_BITS-1:0]      key_q, key_d;
  logic signed [PRIO_W-1:0] prio_q, prio_d;
  spq_pkg::res_t            res_q, res_d;     // result staged for the output register
  spq_pkg::res_t            out_q, out_d;
  logic                     out_vld_q, out_vld_d;

  // RAM port
  logic                        ram_we;
  logic [PTR_W-1:0]            ram_waddr;
  logic [spq_pkg::ENTRY_W-1:0] ram_wdata;
  logic [PTR_W-1:0]            ram_raddr;
  logic [spq_pkg::ENTRY_W-1:0] ram_rdata;

  logic [KEY_BITS-1:0]      rd_key;
  logic signed [PRIO_W-1:0] rd_prio;
  logic                     in_acc;
  logic                     out_free;
  logic                     ins_place;   // the new entry lands at idx_q this cycle
  logic                     srch_hit;
  logic                     srch_last;

  spq_ram #(
    .WIDTH (spq_pkg::ENTRY_W),
    .DEPTH (spq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key  = ram_rdata[spq_pkg::ENTRY_W-1:PRIO_W];
  assign rd_prio = ram_rdata[PRIO_W-1:0];

  assign in_i.ready = (state_q == spq_pkg::S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_free   = ~out_vld_q | out_o.ready;

  // Insert walks from the tail toward the head; stop once the entry ahead outranks the new one.
  assign ins_place = (idx_q == '0) || (rd_prio > prio_q);
  assign srch_hit  = (rd_key == key_q);
  assign srch_last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spq_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (spq_pkg::cmd_e'(in_i.command))
            spq_pkg::CMD_INSERT: begin
              state_d = (cnt_q == spq_pkg::DEPTH_CNT) ? spq_pkg::S_RESP : spq_pkg::S_INS;
            end
            spq_pkg::CMD_POP: begin
              state_d = (cnt_q == '0) ? spq_pkg::S_RESP : spq_pkg::S_POP;
            end
            spq_pkg::CMD_SEARCH: begin
              state_d = (cnt_q == '0) ? spq_pkg::S_RESP : spq_pkg::S_SRCH;
            end
            default: begin
              state_d = spq_pkg::S_RESP;
            end
          endcase
        end
      end
      spq_pkg::S_INS: begin
        if (ins_place) begin
          state_d = spq_pkg::S_RESP;
        end
      end
      spq_pkg::S_POP: begin
        state_d = spq_pkg::S_RESP;
      end
      spq_pkg::S_SRCH: begin
        if (srch_hit || srch_last) begin
          state_d = spq_pkg::S_RESP;
        end
      end
      spq_pkg::S_RESP: begin
        if (out_free) begin
          state_d = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cnt_d     = cnt_q;
    head_d    = head_q;
    idx_d     = idx_q;
    key_d     = key_q;
    prio_d    = prio_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q & ~out_o.ready;
    ram_we    = 1'b0;
    ram_waddr = spq_pkg::phys_addr(head_q, idx_q);
    ram_wdata = ram_rdata;
    ram_raddr = head_q;

    unique case (state_q)
      spq_pkg::S_IDLE: begin
        if (in_acc) begin
          key_d  = in_i.item_key[KEY_BITS-1:0];
          prio_d = in_i.item_priority;
          res_d  = '{status: spq_pkg::ST_OK, key: '0, prio: '0, pos: '0, occ: cnt_q};
          unique case (spq_pkg::cmd_e'(in_i.command))
            spq_pkg::CMD_INSERT: begin
              if (cnt_q == spq_pkg::DEPTH_CNT) begin
                res_d.status = spq_pkg::ST_FULL;
              end else begin
                // Fetch the tail; with an empty queue the read is ignored.
                idx_d     = PTR_W'(cnt_q);
                ram_raddr = spq_pkg::phys_addr(head_q, PTR_W'(cnt_q - CNT_W'(1)));
              end
            end
            spq_pkg::CMD_POP: begin
              if (cnt_q == '0) begin
                res_d.status = spq_pkg::ST_EMPTY;
              end
            end
            spq_pkg::CMD_SEARCH: begin
              idx_d = '0;
              if (cnt_q == '0) begin
                res_d.status = spq_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              // Unused command: report ok and change nothing.
            end
          endcase
        end
      end
      spq_pkg::S_INS: begin
        ram_we = 1'b1;
        if (ins_place) begin
          ram_wdata = {key_q, prio_q};
          cnt_d     = cnt_q + CNT_W'(1);
          res_d     = '{status: spq_pkg::ST_OK, key: '0, prio: '0, pos: idx_q,
                        occ: cnt_q + CNT_W'(1)};
        end else begin
          // Shift the fetched entry one place back and fetch the next one toward the head.
          ram_wdata = ram_rdata;
          idx_d     = idx_q - PTR_W'(1);
          ram_raddr = spq_pkg::phys_addr(head_q, idx_q - PTR_W'(2));
        end
      end
      spq_pkg::S_POP: begin
        head_d = spq_pkg::phys_addr(head_q, PTR_W'(1));
        cnt_d  = cnt_q - CNT_W'(1);
        res_d  = '{status: spq_pkg::ST_OK, key: rd_key, prio: rd_prio, pos: '0,
                   occ: cnt_q - CNT_W'(1)};
      end
      spq_pkg::S_SRCH: begin
        if (srch_hit) begin
          res_d = '{status: spq_pkg::ST_OK, key: rd_key, prio: rd_prio, pos: idx_q,
                    occ: cnt_q};
        end else if (srch_last) begin
          res_d = '{status: spq_pkg::ST_NOT_FOUND, key: '0, prio: '0, pos: '0, occ: cnt_q};
        end else begin
          idx_d     = idx_q + PTR_W'(1);
          ram_raddr = spq_pkg::phys_addr(head_q, idx_q + PTR_W'(1));
        end
      end
      spq_pkg::S_RESP: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spq_pkg::S_IDLE;
      cnt_q     <= '0;
      head_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      head_q    <= head_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers hold their value; no reset needed.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    key_q  <= key_d;
    prio_q <= prio_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.status          = out_q.status;
  assign out_o.result_key      = 64'(out_q.key);
  assign out_o.result_priority = out_q.prio;
  assign out_o.position        = 4'(out_q.pos);
  assign out_o.occupancy       = 5'(out_q.occ);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= spq_pkg::DEPTH_CNT)
    else $error("entry count above depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, head_q} < spq_pkg::DEPTH_WRAP)
    else $error("head pointer out of range");

  a_we_ins_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == spq_pkg::S_INS))
    else $error("RAM write outside insert walk");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != spq_pkg::S_IDLE))
    else $error("accepted item did not leave idle");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.status == spq_pkg::ST_FULL)) |-> (out_q.occ == spq_pkg::DEPTH_CNT))
    else $error("full status with queue not full");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.status == spq_pkg::ST_EMPTY)) |-> (out_q.occ == '0))
    else $error("empty status with entries held");
`endif

endmodule

FILE: hw/rtl/spq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: verif/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue: directed and random command items,
// checked against an in-bench model of the sorted entry list. Depends on spq_pkg, spq_if and sorted_priority_queue.
module tb_sorted_priority_queue;

  localparam int DEPTH    = spq_pkg::DEPTH;
  localparam int KEY_BITS = spq_pkg::KEY_BITS;
  localparam int PTR_W    = spq_pkg::PTR_W;
  localparam int CNT_W    = spq_pkg::CNT_W;

  // The reserved command value; the block must ignore it and report only occupancy.
  localparam logic [1:0]  CMD_RESERVED = 2'd3;
  localparam logic [63:0] KEY_MASK     = {64{1'b1}} >> (64 - KEY_BITS);
  localparam logic [63:0] KEY_ALL_ONES = {64{1'b1}};
  localparam logic signed [31:0] PRIO_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
  // Cycles without any accepted item before the run is declared hung. The longest honest
  // quiet stretch is the receiver hold-off below plus a long gap and a full RAM walk.
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = DEPTH + 12;
  localparam int RANDOM_ITEMS = 400;

  logic clk;
  logic rst_n = 1'b0;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Model of the queue contents, kept in descending priority order from the head.
  logic [63:0]        held_key [DEPTH];
  logic signed [31:0] held_prio[DEPTH];
  int                 held_count = 0;

  spq_pkg::res_t pending_results[$];

  int  n_sent = 0;
  int  n_checked = 0;
  int  n_errors = 0;
  int  n_full = 0;
  int  n_empty = 0;
  int  n_miss = 0;
  int  n_ignored = 0;
  int  peak_held = 0;
  int  idle_cycles = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_gaps_on = 1'b1;
  int  rx_hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length for either side: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit enable);
    int roll;
    roll = $urandom_range(0, 99);
    if (!enable || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one command to the model and return the result item it must produce.
  function automatic spq_pkg::res_t predict_queue_op(input logic [1:0] cmd,
                                                     input logic [63:0] key,
                                                     input logic signed [31:0] prio);
    spq_pkg::res_t r;
    int            slot;
    int            i;
    logic [63:0]   k;
    r = '0;
    k = key & KEY_MASK;
    case (cmd)
      spq_pkg::CMD_INSERT: begin
        if (held_count >= DEPTH) begin
          r.status = spq_pkg::ST_FULL;
          n_full++;
        end else begin
          // Walk past strictly higher priorities only, so a tie lands ahead of its peers.
          slot = 0;
          while (slot < held_count && held_prio[slot] > prio) slot++;
          for (i = held_count; i > slot; i--) begin
            held_key[i]  = held_key[i-1];
            held_prio[i] = held_prio[i-1];
          end
          held_key[slot]  = k;
          held_prio[slot] = prio;
          held_count++;
          r.pos = PTR_W'(slot);
          if (held_count > peak_held) peak_held = held_count;
        end
      end
      spq_pkg::CMD_POP: begin
        if (held_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.key  = held_key[0];
          r.prio = held_prio[0];
          for (i = 1; i < held_count; i++) begin
            held_key[i-1]  = held_key[i];
            held_prio[i-1] = held_prio[i];
          end
          held_count--;
        end
      end
      spq_pkg::CMD_SEARCH: begin
        r.status = spq_pkg::ST_NOT_FOUND;
        for (i = 0; i < held_count; i++) begin
          if (held_key[i] == k) begin
            r.status = spq_pkg::ST_OK;
            r.key    = held_key[i];
            r.prio   = held_prio[i];
            r.pos    = PTR_W'(i);
            break;
          end
        end
        if (r.status == spq_pkg::ST_NOT_FOUND) n_miss++;
      end
      default: n_ignored++;
    endcase
    r.occ = CNT_W'(held_count);
    return r;
  endfunction

  // Offer one item after an optional gap, hold it until accepted, then queue its result.
  task automatic send_cmd(input logic [1:0] cmd, input logic [63:0] key,
                          input logic signed [31:0] prio);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.item_key      <= key;
    in_ch.item_priority <= prio;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(predict_queue_op(cmd, key, prio));
    n_sent++;
  endtask

  function automatic logic [63:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Key of a random entry now held; a fresh random key when the queue is empty.
  function automatic logic [63:0] pick_held_key();
    if (held_count == 0) return random_key();
    return held_key[$urandom_range(0, held_count - 1)];
  endfunction

  // Mix small priorities (many ties), the two extremes and the full signed range.
  function automatic logic signed [31:0] random_prio();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return int'($urandom_range(0, 7)) - 4;
    if (roll < 45) return PRIO_MAX;
    if (roll < 50) return PRIO_MIN;
    return $urandom;
  endfunction

  // Operations on an empty queue, including the reserved command value.
  task automatic test_empty_queue();
    send_cmd(spq_pkg::CMD_POP, '0, '0);
    send_cmd(spq_pkg::CMD_SEARCH, KEY_ALL_ONES, '0);
    send_cmd(CMD_RESERVED, KEY_ALL_ONES, PRIO_MIN);
  endtask

  // Fill to DEPTH with extreme keys, extreme priorities and ties (one with the head),
  // then insert into the full queue and search the tail, a miss, an ignored command and a pop.
  task automatic test_fill_and_overflow();
    logic [63:0]        key;
    logic [63:0]        tail_key;
    logic signed [31:0] prio;
    int                 i;
    tail_key = '0;
    for (i = 0; i < DEPTH; i++) begin
      key = random_key();
      case (i)
        0:       begin key = '0;           prio = '0;       end
        1:       begin key = KEY_ALL_ONES; prio = PRIO_MAX; end
        2:       begin tail_key = key;     prio = PRIO_MIN; end
        3:       prio = PRIO_MAX;  // tie with the head: must become the new head
        4:       prio = '0;        // tie in the middle of the list
        default: prio = int'($urandom_range(0, 20)) - 10;
      endcase
      send_cmd(spq_pkg::CMD_INSERT, key, prio);
    end
    send_cmd(spq_pkg::CMD_INSERT, random_key(), PRIO_MAX);
    send_cmd(spq_pkg::CMD_SEARCH, tail_key, '0);
    send_cmd(spq_pkg::CMD_SEARCH, random_key(), '0);
    send_cmd(CMD_RESERVED, '0, PRIO_MAX);
    send_cmd(spq_pkg::CMD_POP, '0, '0);
  endtask

  // Stall the receiver for a long stretch while the sender keeps offering items back to
  // back, so the output register fills and the input side is held off.
  task automatic test_backpressure();
    int i;
    tx_gaps_on  = 1'b0;
    rx_hold_req <= HOLD_CYCLES;
    for (i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_cmd(spq_pkg::CMD_SEARCH, pick_held_key(), '0);
      else            send_cmd(spq_pkg::CMD_INSERT, random_key(), random_prio());
    end
    tx_gaps_on = 1'b1;
  endtask

  // Random commands in phases that push the queue toward full, toward empty, or keep it
  // balanced; the last phase of each round runs without gaps on either side.
  task automatic test_random_mix(input int n_items);
    int          done;
    int          phase;
    int          roll;
    int          ins_cut;
    int          pop_cut;
    logic [1:0]  cmd;
    logic [63:0] key;
    done = 0;
    while (done < n_items) begin
      phase = (done / 40) % 4;
      tx_gaps_on = (phase != 3);
      rx_gaps_on = (phase != 3);
      case (phase)
        0:       begin ins_cut = 65; pop_cut = 85; end
        1:       begin ins_cut = 25; pop_cut = 75; end
        default: begin ins_cut = 40; pop_cut = 70; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3)            cmd = CMD_RESERVED;
      else if (roll < ins_cut) cmd = spq_pkg::CMD_INSERT;
      else if (roll < pop_cut) cmd = spq_pkg::CMD_POP;
      else                     cmd = spq_pkg::CMD_SEARCH;
      // Searches mostly hit a held key; some inserts duplicate one to test first match.
      roll = $urandom_range(0, 99);
      if (cmd == spq_pkg::CMD_SEARCH) key = (roll < 60) ? pick_held_key() : random_key();
      else                            key = (roll < 20) ? pick_held_key() : random_key();
      send_cmd(cmd, key, random_prio());
      if (cmd != CMD_RESERVED) done++;
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Receiver: random stalls, plus a long hold-off counted here when a test requests one.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        stall_left = rx_hold_req;
        rx_hold_req <= 0;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(rx_gaps_on);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] seen);
    $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
    n_errors++;
  endtask

  // Compare every accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin
    spq_pkg::res_t got;
    spq_pkg::res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status = spq_pkg::status_e'(out_ch.status);
      got.key    = out_ch.result_key;
      got.prio   = out_ch.result_priority;
      got.pos    = out_ch.position;
      got.occ    = out_ch.occupancy;
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with none expected, actual status %0d key 0x%0h",
                 $time, got.status, got.key);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.status !== want.status) report_mismatch("status", want.status, got.status);
        if (got.key !== want.key) report_mismatch("result_key", want.key, got.key);
        if (got.prio !== want.prio) report_mismatch("result_priority", want.prio, got.prio);
        if (got.pos !== want.pos) report_mismatch("position", want.pos, got.pos);
        if (got.occ !== want.occ) report_mismatch("occupancy", want.occ, got.occ);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.command       <= spq_pkg::CMD_INSERT;
    in_ch.item_key      <= '0;
    in_ch.item_priority <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_fill_and_overflow();
    test_backpressure();
    test_random_mix(RANDOM_ITEMS);

    // Drop valid, wait for every result, then give the block time to misbehave.
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d ignored), checked %0d results, peak occupancy %0d",
             n_sent, n_ignored, n_checked, peak_held);
    $display("Saw %0d inserts into a full queue, %0d pops when empty, %0d search misses",
             n_full, n_empty, n_miss);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_ram.sv
hw/rtl/sorted_priority_queue.sv
verif/tb_sorted_priority_queue.sv
